>>> hw/rtl/prc_pkg.sv
package prc_pkg;

	// default sizes
	localparam int unsigned COORD_BITS_DEF      = 32;
	localparam int unsigned SINE_INDEX_BITS_DEF = 10;

	// trig values are signed Q1.15
	localparam int unsigned TRIG_BITS = 16;
	localparam int unsigned TRIG_FRAC = 15;

	// binary angle: 65536 units per turn
	localparam int unsigned ANGLE_BITS    = 16;
	localparam logic [15:0] ANGLE_QUARTER = 16'h4000;

	// pi/2 with 30 fraction bits
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Taylor series divisors (2n)(2n+1), n = 1..10
	localparam int unsigned TAYLOR_TERMS = 10;
	localparam int unsigned TAYLOR_DEN [TAYLOR_TERMS] =
		'{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Y    = 3'd1,
		REG_CENTER_Z    = 3'd2,
		REG_YAW_ANGLE   = 3'd3,
		REG_PITCH_ANGLE = 3'd4
	} reg_index_t;

	// stage enables handed to a rotation unit
	typedef struct packed {
		logic s1;
		logic s2;
	} rot_en_t;

	// quarter-wave sine entry k of a table with 2^ib steps, Q1.15, clipped to 32767
	function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned ib);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] r;
		int unsigned        n;
		x    = (HALF_PI_Q30 * 64'(k) + ((64'd1 << ib) >> 1)) >> ib;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		for (n = 0; n < TAYLOR_TERMS; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DEN[n];
			if (n % 2 == 0) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		r = (sum + 64'sd16384) >>> 15;
		if (r > 64'sd32767) begin
			r = 64'sd32767;
		end
		return r[14:0];
	endfunction

endpackage

>>> hw/rtl/point_rotate_about_center_top.sv
// Rotates 3D points about a configured center: yaw in the x-z plane, then
// pitch in the y-z plane, results saturated to the coordinate range.
// Input stream s_*: one point per transfer, x/y/z packed in s_tdata.
// Output stream m_*: rotated x/y/z in m_tdata, clip flag in m_tuser.
// Config port: cfg_we/cfg_index/cfg_data write center x/y/z, yaw and pitch.
// Angle writes read the sine table into a register, and the new sine and
// cosine load from it into their registers. Write only while idle.
// Stages from an input transfer to m_tvalid: subtract, yaw products, yaw
// sums, pitch products, pitch sums, center add and clip; each stage does
// multiplies or adds. Throughput: one point per cycle unless m_tready stalls.
// Each stage holds only while it is full and the next stage holds, so a
// stalled m_tready backs up through the stages without loss or repeat and
// empty stages still fill. s_tready drops only when every stage is full.
// Reset clears all valid bits, centers and angles to zero (cosine 32767/32768,
// sine zero).
module point_rotate_about_center_top #(
	parameter int unsigned COORD_BITS      = prc_pkg::COORD_BITS_DEF,
	parameter int unsigned SINE_INDEX_BITS = prc_pkg::SINE_INDEX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave side
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// point_x, point_y, point_z, zero pad
	input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// master side
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// rotated_x, rotated_y, rotated_z, zero pad
	output logic [((3*COORD_BITS+7)/8)*8-1:0] m_tdata,
	// saturated
	output logic                          m_tuser,
	// configuration
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [COORD_BITS-1:0]         cfg_data
);

	localparam int unsigned CB     = COORD_BITS;
	localparam int unsigned TDW    = ((3*CB+7)/8)*8;
	localparam int unsigned DW     = CB + 1;   // center-relative
	localparam int unsigned YW     = CB + 2;   // after yaw
	localparam int unsigned PW     = CB + 3;   // after pitch
	localparam int unsigned SUMW   = CB + 4;   // center added back
	localparam int unsigned TW     = prc_pkg::TRIG_BITS;
	localparam int unsigned TBL_N  = 2 ** SINE_INDEX_BITS;
	localparam int unsigned IW     = SINE_INDEX_BITS + 1;
	localparam logic signed [SUMW-1:0] CMAX = SUMW'((64'sd1 <<< (CB - 1)) - 64'sd1);
	localparam logic signed [SUMW-1:0] CMIN = SUMW'(-(64'sd1 <<< (CB - 1)));

	// quarter-wave sine table, constant
	logic [14:0] sine_tbl [TBL_N+1];

	for (genvar k = 0; k <= TBL_N; k++) begin : g_tbl
		assign sine_tbl[k] = prc_pkg::sine_entry(k, SINE_INDEX_BITS);
	end

	// configuration registers
	logic signed [CB-1:0] cx_q, cy_q, cz_q;
	logic signed [TW-1:0] yaw_cos_q, yaw_sin_q, pitch_cos_q, pitch_sin_q;

	// trig lookup of the written angle: slot 0 sine, slot 1 cosine
	logic [15:0]          ang [2];
	logic [IW-1:0]        tidx [2];
	logic [14:0]          ent_q [2];
	logic [1:0]           neg_q;
	logic                 ang_we_q, ang_pitch_q;
	logic signed [TW-1:0] trig [2];

	always_comb begin
		ang[0] = cfg_data[15:0];
		ang[1] = cfg_data[15:0] + prc_pkg::ANGLE_QUARTER;
		for (int j = 0; j < 2; j++) begin
			tidx[j] = {1'b0, ang[j][13 -: SINE_INDEX_BITS]};
			if (ang[j][14]) begin
				tidx[j] = IW'(TBL_N) - tidx[j];
			end
		end
	end

	// registered table read, sign kept alongside
	always_ff @(posedge clk) begin
		ent_q[0] <= sine_tbl[tidx[0]];
		ent_q[1] <= sine_tbl[tidx[1]];
		neg_q    <= {ang[1][15], ang[0][15]};
	end

	// negate in the upper half of the turn
	always_comb begin
		for (int j = 0; j < 2; j++) begin
			if (neg_q[j]) begin
				trig[j] = -$signed({1'b0, ent_q[j]});
			end else begin
				trig[j] = $signed({1'b0, ent_q[j]});
			end
		end
	end

	// register writes; angle sine and cosine load from the registered table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q        <= '0;
			cy_q        <= '0;
			cz_q        <= '0;
			ang_we_q    <= 1'b0;
			ang_pitch_q <= 1'b0;
			yaw_sin_q   <= TW'(prc_pkg::sine_entry(0, SINE_INDEX_BITS));
			yaw_cos_q   <= TW'(prc_pkg::sine_entry(TBL_N, SINE_INDEX_BITS));
			pitch_sin_q <= TW'(prc_pkg::sine_entry(0, SINE_INDEX_BITS));
			pitch_cos_q <= TW'(prc_pkg::sine_entry(TBL_N, SINE_INDEX_BITS));
		end else begin
			ang_we_q    <= cfg_we && (cfg_index == prc_pkg::REG_YAW_ANGLE ||
				cfg_index == prc_pkg::REG_PITCH_ANGLE);
			ang_pitch_q <= (cfg_index == prc_pkg::REG_PITCH_ANGLE);
			if (cfg_we) begin
				unique case (cfg_index)
					prc_pkg::REG_CENTER_X: cx_q <= cfg_data;
					prc_pkg::REG_CENTER_Y: cy_q <= cfg_data;
					prc_pkg::REG_CENTER_Z: cz_q <= cfg_data;
					default: ;
				endcase
			end
			if (ang_we_q) begin
				if (ang_pitch_q) begin
					pitch_sin_q <= trig[0];
					pitch_cos_q <= trig[1];
				end else begin
					yaw_sin_q <= trig[0];
					yaw_cos_q <= trig[1];
				end
			end
		end
	end

	// stage enables: a stage loads when empty or when the next one moves
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	assign en_s6 = !vld_s6 || m_tready;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= s_tvalid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
		end
	end

	// stage 1: subtract the center
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dx_s1 <= DW'($signed(s_tdata[CB-1:0]))      - DW'(cx_q);
			dy_s1 <= DW'($signed(s_tdata[2*CB-1:CB]))   - DW'(cy_q);
			dz_s1 <= DW'($signed(s_tdata[3*CB-1:2*CB])) - DW'(cz_q);
		end
	end

	// stages 2-3: yaw rotation in the x-z plane
	prc_pkg::rot_en_t     yaw_en, pitch_en;
	logic signed [YW-1:0] rx_s3, rz_s3;

	assign yaw_en = '{s1: en_s2, s2: en_s3};

	prc_rot #(
		.A_BITS(DW),
		.B_BITS(DW),
		.O_BITS(YW)
	) u_yaw (
		.clk(clk),
		.en (yaw_en),
		.a  (dx_s1),
		.b  (dz_s1),
		.c  (yaw_cos_q),
		.s  (yaw_sin_q),
		.p  (rx_s3),
		.q  (rz_s3)
	);

	// y rides along the yaw stages
	logic signed [DW-1:0] dy_s2, dy_s3;

	always_ff @(posedge clk) begin
		if (en_s2) dy_s2 <= dy_s1;
		if (en_s3) dy_s3 <= dy_s2;
	end

	// stages 4-5: pitch rotation in the y-z plane, using y before update
	logic signed [PW-1:0] ry_s5, rz_s5;

	assign pitch_en = '{s1: en_s4, s2: en_s5};

	prc_rot #(
		.A_BITS(DW),
		.B_BITS(YW),
		.O_BITS(PW)
	) u_pitch (
		.clk(clk),
		.en (pitch_en),
		.a  (dy_s3),
		.b  (rz_s3),
		.c  (pitch_cos_q),
		.s  (pitch_sin_q),
		.p  (ry_s5),
		.q  (rz_s5)
	);

	// x rides along the pitch stages
	logic signed [YW-1:0] rx_s4, rx_s5;

	always_ff @(posedge clk) begin
		if (en_s4) rx_s4 <= rx_s3;
		if (en_s5) rx_s5 <= rx_s4;
	end

	// stage 6: add the center back and saturate
	function automatic logic [CB:0] clip_coord(input logic signed [SUMW-1:0] v);
		logic [CB:0] res;
		if (v > CMAX) begin
			res = {1'b1, CMAX[CB-1:0]};
		end else if (v < CMIN) begin
			res = {1'b1, CMIN[CB-1:0]};
		end else begin
			res = {1'b0, v[CB-1:0]};
		end
		return res;
	endfunction

	logic [CB:0]    cl_x, cl_y, cl_z;
	logic [CB-1:0]  ox_s6, oy_s6, oz_s6;
	logic           sat_s6;

	always_comb begin
		cl_x = clip_coord(SUMW'(rx_s5) + SUMW'(cx_q));
		cl_y = clip_coord(SUMW'(ry_s5) + SUMW'(cy_q));
		cl_z = clip_coord(SUMW'(rz_s5) + SUMW'(cz_q));
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			ox_s6  <= cl_x[CB-1:0];
			oy_s6  <= cl_y[CB-1:0];
			oz_s6  <= cl_z[CB-1:0];
			sat_s6 <= cl_x[CB] | cl_y[CB] | cl_z[CB];
		end
	end

	assign m_tvalid = vld_s6;
	assign m_tdata  = TDW'({oz_s6, oy_s6, ox_s6});
	assign m_tuser  = sat_s6;

endmodule

>>> hw/rtl/prc_rot.sv
// Plane rotation: p = round(a*c + b*s), q = round(b*c - a*s), scaled by 2^-15.
// Two stages: products, then sums with round half up.
module prc_rot #(
	parameter int unsigned A_BITS = 33,
	parameter int unsigned B_BITS = 33,
	parameter int unsigned O_BITS = 34
) (
	input  logic                              clk,
	input  prc_pkg::rot_en_t                  en,
	input  logic signed [A_BITS-1:0]          a,
	input  logic signed [B_BITS-1:0]          b,
	input  logic signed [prc_pkg::TRIG_BITS-1:0] c,
	input  logic signed [prc_pkg::TRIG_BITS-1:0] s,
	output logic signed [O_BITS-1:0]          p,
	output logic signed [O_BITS-1:0]          q
);

	localparam int unsigned TW     = prc_pkg::TRIG_BITS;
	localparam int unsigned TF     = prc_pkg::TRIG_FRAC;
	localparam int unsigned PA     = A_BITS + TW;
	localparam int unsigned PB     = B_BITS + TW;
	localparam int unsigned MAXW   = (A_BITS > B_BITS) ? A_BITS : B_BITS;
	localparam int unsigned SW     = MAXW + TW + 1;
	localparam logic signed [SW-1:0] RND = SW'(2 ** (TF - 1));

	logic signed [PA-1:0] ac_s1, as_s1;
	logic signed [PB-1:0] bc_s1, bs_s1;
	logic signed [SW-1:0] sum_p, sum_q;
	logic signed [O_BITS-1:0] p_s2, q_s2;

	// stage 1: four products
	always_ff @(posedge clk) begin
		if (en.s1) begin
			ac_s1 <= PA'(a) * PA'(c);
			as_s1 <= PA'(a) * PA'(s);
			bc_s1 <= PB'(b) * PB'(c);
			bs_s1 <= PB'(b) * PB'(s);
		end
	end

	// stage 2: exact sums, round half up, drop 15 fraction bits
	assign sum_p = SW'(ac_s1) + SW'(bs_s1) + RND;
	assign sum_q = SW'(bc_s1) - SW'(as_s1) + RND;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p_s2 <= sum_p[O_BITS+TF-1:TF];
			q_s2 <= sum_q[O_BITS+TF-1:TF];
		end
	end

	assign p = p_s2;
	assign q = q_s2;

endmodule
